>>> src/fbh_pkg.sv
// Shared types and constants of the fixed bin histogram unit.
package fbh_pkg;

  localparam int unsigned VALUE_W = 32;  // Q16.16 sample and range edges
  localparam int unsigned WIDTH_W = 31;  // bin width register
  localparam int unsigned NBINS_W = 7;   // bins-in-use register
  localparam int unsigned RIDX_W  = 6;   // read index and reported bin index
  localparam int unsigned COUNT_W = 32;  // bin counter
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd3;

  // Reset values of the configuration registers
  localparam logic [VALUE_W-1:0] RANGE_MIN_RST   = 32'd0;
  localparam logic [VALUE_W-1:0] RANGE_MAX_RST   = 32'd4063232;
  localparam logic [WIDTH_W-1:0] BIN_STEP_RST    = 31'd65536;
  localparam logic [NBINS_W-1:0] BINS_IN_USE_RST = 7'd64;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [WIDTH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> src/fbh_if.sv
// Valid/ready channel interfaces for commands and results.
interface fbh_in_if import fbh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [VALUE_W-1:0] sample_value;
  logic [RIDX_W-1:0]         read_index;

  modport source (output valid, command, sample_value, read_index, input ready);
  modport sink (input valid, command, sample_value, read_index, output ready);
endinterface

interface fbh_out_if import fbh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RIDX_W-1:0]  bin_index;
  logic [COUNT_W-1:0] bin_count;

  modport source (output valid, bin_index, bin_count, input ready);
  modport sink (input valid, bin_index, bin_count, output ready);
endinterface

>>> src/fixed_bin_histogram_unit.sv
// Top level of the fixed bin histogram unit: sequencer, config registers, result register.
//
//  channel   | dir | transaction carries
//  ----------+-----+---------------------------------------------
//  samples   | in  | command, sample_value (Q16.16), read_index
//  results   | out | bin_index, bin_count (count after the command)
//  cfg_*     | in  | register write: index 0..3, data, no handshake
//
// A read or an underflow/overflow add passes CLASSIFY, ADDR and DATA after IDLE;
// an add in range also waits in DIV for the divider's done between CLASSIFY and
// ADDR. The result is registered in the output register when DATA loads it.
// After reset the count store is swept to zero, all MAX_BINS bins, samples not ready.
// A stalled result holds in the output register; the next transaction is accepted
// meanwhile and waits at its store access until the result is taken.
module fixed_bin_histogram_unit import fbh_pkg::*; #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fbh_in_if.sink                samples,
  fbh_out_if.source             results
);

  localparam int unsigned BIDX_W = $clog2(MAX_BINS);

  typedef enum logic [2:0] {
    CLEAR, IDLE, CLASSIFY, DIV, ADDR, DATA
  } state_t;

  state_t state;

  // configuration
  logic signed [VALUE_W-1:0] range_min;
  logic signed [VALUE_W-1:0] range_max;
  logic [WIDTH_W-1:0]        bin_step;
  logic [NBINS_W-1:0]        bins_in_use;

  // captured transaction
  logic                      op;
  logic signed [VALUE_W-1:0] sample;
  logic [RIDX_W-1:0]         ridx;
  logic [BIDX_W-1:0]         bin;
  logic [BIDX_W-1:0]         clr_addr;

  // result register
  logic               out_valid;
  logic [RIDX_W-1:0]  out_idx;
  logic [COUNT_W-1:0] out_count;

  logic [BIDX_W-1:0]  last_bin;
  logic               read_oob;
  logic               out_load;
  logic [BIDX_W-1:0]  div_bin;
  logic [COUNT_W-1:0] rdata;
  logic [BIDX_W-1:0]  raddr;
  logic               mem_we;
  logic [BIDX_W-1:0]  waddr;
  logic [COUNT_W-1:0] wdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Last bin in use, bins_in_use clamped to [2, MAX_BINS]
  always_comb begin
    if (bins_in_use < NBINS_W'(2)) begin
      last_bin = BIDX_W'(1);
    end else if (32'(bins_in_use) > MAX_BINS) begin
      last_bin = BIDX_W'(MAX_BINS - 1);
    end else begin
      last_bin = BIDX_W'(bins_in_use - 1'b1);
    end
  end

  // Divider quotient plus one, clamped to the last bin
  assign div_bin = (div_rsp.quotient >= 32'(last_bin)) ? last_bin
                                                        : BIDX_W'(div_rsp.quotient) + 1'b1;

  // Reads beyond the store report zero
  assign read_oob = 32'(ridx) >= MAX_BINS;

  assign raddr    = (op == CMD_READ) ? BIDX_W'(ridx) : bin;
  assign out_load = (state == DATA) && (!out_valid || results.ready);

  assign mem_we = (state == CLEAR) || (out_load && (op == CMD_ADD));
  assign waddr  = (state == CLEAR) ? clr_addr : bin;
  assign wdata  = (state == CLEAR) ? '0 : rdata + 1'b1;

  assign div_req.start    = (state == CLASSIFY) && (op == CMD_ADD)
                            && !(sample < range_min) && !(sample >= range_max);
  assign div_req.dividend = sample - range_min;  // fits unsigned once sample >= range_min
  assign div_req.divisor  = (bin_step == '0) ? WIDTH_W'(1) : bin_step;

  assign samples.ready     = (state == IDLE);
  assign results.valid     = out_valid;
  assign results.bin_index = out_idx;
  assign results.bin_count = out_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min   <= RANGE_MIN_RST;
      range_max   <= RANGE_MAX_RST;
      bin_step    <= BIN_STEP_RST;
      bins_in_use <= BINS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN:   range_min   <= cfg_data;
        REG_RANGE_MAX:   range_max   <= cfg_data;
        REG_BIN_STEP:    bin_step    <= cfg_data[WIDTH_W-1:0];
        REG_BINS_IN_USE: bins_in_use <= cfg_data[NBINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // a result taken with no new one loaded empties the register
      if (results.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BIDX_W'(MAX_BINS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (samples.valid) begin
            op     <= samples.command;
            sample <= samples.sample_value;
            ridx   <= samples.read_index;
            state  <= CLASSIFY;
          end
        end
        CLASSIFY: begin
          if (op == CMD_READ) begin
            state <= ADDR;
          end else if (sample < range_min) begin
            bin   <= '0;
            state <= ADDR;
          end else if (sample >= range_max) begin
            bin   <= last_bin;
            state <= ADDR;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          if (div_rsp.done) begin
            bin   <= div_bin;
            state <= ADDR;
          end
        end
        ADDR: begin
          state <= DATA;
        end
        DATA: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (op == CMD_ADD) begin
              out_idx   <= RIDX_W'(bin);
              out_count <= rdata + 1'b1;
            end else begin
              out_idx   <= ridx;
              out_count <= read_oob ? '0 : rdata;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  fbh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fbh_mem #(
    .DEPTH (MAX_BINS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

`ifndef ASSERT_OFF
  // A divide result only arrives while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == DIV))
    else $error("divider finished outside DIV");

  // Counts are written back only by an add that delivers its result
  a_write_is_add: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != CLEAR)) |-> (out_load && (op == CMD_ADD)))
    else $error("count store written outside an add");

  // An add never touches a bin beyond the last one in use
  a_bin_in_use: assert property (@(posedge clk) disable iff (rst)
    (out_load && (op == CMD_ADD)) |-> (bin <= last_bin))
    else $error("add selected a bin beyond the last in use");

  // A freshly loaded add result reports the incremented count of its bin
  a_add_result: assert property (@(posedge clk) disable iff (rst)
    (out_load && (op == CMD_ADD)) |=> (results.valid
                                       && (results.bin_count == $past(rdata) + 1'b1)))
    else $error("add result does not match the incremented count");
`endif

endmodule

>>> src/fbh_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module fbh_div import fbh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VALUE_W-1:0]   quo;   // dividend shifts out, quotient shifts in
  logic [VALUE_W-1:0]   rem;
  logic [WIDTH_W-1:0]   dvs;
  logic [VALUE_W-1:0]   rem_sh;
  logic [VALUE_W:0]     diff;

  assign rem_sh = {rem[VALUE_W-2:0], quo[VALUE_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!diff[VALUE_W]) begin
          rem <= diff[VALUE_W-1:0];
          quo <= {quo[VALUE_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[VALUE_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> src/fbh_mem.sv
// Bin count store: one write port, one registered read port.
module fbh_mem import fbh_pkg::*; #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [COUNT_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
